/* hw/rtl/jsu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape unit: the command that
// the decoder hands to the output serializer, result kinds and error codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_BAD_ESC  = 3'd0;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd1;
  localparam logic [2:0] ERR_LONE_LOW = 3'd2;
  localparam logic [2:0] ERR_LOW_EXP  = 3'd3;
  localparam logic [2:0] ERR_BAD_LOW  = 3'd4;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_CP,
    OP_END,
    OP_ERR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [20:0] cp;
    logic [2:0]  err;
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/json_string_unescape_utf8_unit.sv */
`default_nettype none
// An accepted byte goes through the command queue and then the registered output stage.
// Throughput: one input byte per cycle while the four-entry command queue has room.
// Each escape decoded to a code point yields one result beat per UTF-8 byte (up to four).
// Sustained rate: the output serializer gives one result beat per cycle while res_stall is low.
// Reset is synchronous: the decoder returns to the plain string body and the queue empties.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string body unescaper: escape decoding with UTF-16 surrogate pairing
// in front, a small command queue, and a UTF-8 serializer at the output.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       restart,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic [2:0]      error_code,
  output logic            last
);

  jsu_pkg::cmd_t push_cmd;
  jsu_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          head_valid;
  logic          full;
  logic          accept;

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .restart   (restart),
    .cmd       (push_cmd),
    .push      (push)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule
`default_nettype wire

/* hw/rtl/jsu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder. Tracks the string body, escape and surrogate state for each
// accepted byte and emits at most one command per byte toward the queue.
// ----------------------------------------------------------------------------
module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         restart,
  output jsu_pkg::cmd_t     cmd,
  output logic              push
);

  typedef enum logic [2:0] {
    ST_STR,
    ST_ESC,
    ST_HEX,
    ST_SUR1,
    ST_SUR2,
    ST_ERR
  } state_t;

  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  state_t      state, state_eff, state_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic        have_high, have_high_eff, have_high_next;
  logic [11:0] acc, acc_next;
  logic [9:0]  hi, hi_next;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] v;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (data_byte inside {[8'h30:8'h39]}) begin
      hex_d = data_byte[3:0];
    end else if (data_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_d = data_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    state_eff      = restart ? ST_STR : state;
    have_high_eff  = restart ? 1'b0 : have_high;
    state_next     = state_eff;
    hex_cnt_next   = hex_cnt;
    have_high_next = have_high_eff;
    acc_next       = acc;
    hi_next        = hi;
    v              = {acc, hex_d};
    push           = 1'b0;
    cmd.op         = jsu_pkg::OP_BYTE;
    cmd.cp         = {13'd0, data_byte};
    cmd.err        = jsu_pkg::ERR_BAD_ESC;
    case (state_eff)
      ST_STR: begin
        if (data_byte == CH_BSL) begin
          state_next = ST_ESC;
        end else if (data_byte == CH_QUOTE) begin
          push   = 1'b1;
          cmd.op = jsu_pkg::OP_END;
        end else begin
          push = 1'b1;
        end
      end
      ST_ESC: begin
        state_next = ST_STR;
        push       = 1'b1;
        case (data_byte)
          CH_QUOTE, CH_BSL, CH_SLASH: cmd.cp = {13'd0, data_byte};
          CH_B: cmd.cp = 21'h08;
          CH_F: cmd.cp = 21'h0c;
          CH_N: cmd.cp = 21'h0a;
          CH_R: cmd.cp = 21'h0d;
          CH_T: cmd.cp = 21'h09;
          CH_U: begin
            push         = 1'b0;
            state_next   = ST_HEX;
            hex_cnt_next = 2'd0;
            acc_next     = 12'd0;
          end
          default: begin
            cmd.op     = jsu_pkg::OP_ERR;
            cmd.err    = jsu_pkg::ERR_BAD_ESC;
            state_next = ST_ERR;
          end
        endcase
      end
      ST_HEX: begin
        if (!hex_ok) begin
          push       = 1'b1;
          cmd.op     = jsu_pkg::OP_ERR;
          cmd.err    = jsu_pkg::ERR_BAD_HEX;
          state_next = ST_ERR;
        end else if (hex_cnt != 2'd3) begin
          acc_next     = {acc[7:0], hex_d};
          hex_cnt_next = hex_cnt + 2'd1;
        end else if (!have_high_eff) begin
          if (v < 16'hd800 || v >= 16'he000) begin
            push       = 1'b1;
            cmd.op     = jsu_pkg::OP_CP;
            cmd.cp     = {5'd0, v};
            state_next = ST_STR;
          end else if (v < 16'hdc00) begin
            hi_next        = v[9:0];
            have_high_next = 1'b1;
            state_next     = ST_SUR1;
          end else begin
            push       = 1'b1;
            cmd.op     = jsu_pkg::OP_ERR;
            cmd.err    = jsu_pkg::ERR_LONE_LOW;
            state_next = ST_ERR;
          end
        end else if (v[15:10] == 6'b110111) begin
          push           = 1'b1;
          cmd.op         = jsu_pkg::OP_CP;
          cmd.cp         = 21'h10000 + {1'b0, hi, v[9:0]};
          have_high_next = 1'b0;
          state_next     = ST_STR;
        end else begin
          push       = 1'b1;
          cmd.op     = jsu_pkg::OP_ERR;
          cmd.err    = jsu_pkg::ERR_BAD_LOW;
          state_next = ST_ERR;
        end
      end
      ST_SUR1: begin
        if (data_byte == CH_BSL) begin
          state_next = ST_SUR2;
        end else begin
          push       = 1'b1;
          cmd.op     = jsu_pkg::OP_ERR;
          cmd.err    = jsu_pkg::ERR_LOW_EXP;
          state_next = ST_ERR;
        end
      end
      ST_SUR2: begin
        if (data_byte == CH_U) begin
          state_next   = ST_HEX;
          hex_cnt_next = 2'd0;
          acc_next     = 12'd0;
        end else begin
          push       = 1'b1;
          cmd.op     = jsu_pkg::OP_ERR;
          cmd.err    = jsu_pkg::ERR_LOW_EXP;
          state_next = ST_ERR;
        end
      end
      default: begin
        state_next = ST_ERR;
      end
    endcase
    push = push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_STR;
      hex_cnt   <= 2'd0;
      have_high <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      hex_cnt   <= hex_cnt_next;
      have_high <= have_high_next;
    end
    if (accept) begin
      acc <= acc_next;
      hi  <= hi_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.op == jsu_pkg::OP_ERR) |=> (state == ST_ERR))
    else $error("error command without entering the error state");
  a_high_in_sur: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUR1 || state == ST_SUR2) |-> have_high)
    else $error("waiting for a low surrogate without a high surrogate");
`endif

endmodule
`default_nettype wire

/* hw/rtl/jsu_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// Small command queue between the decoder and the serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output jsu_pkg::cmd_t      head,
  output logic               head_valid,
  output logic               full
);

  jsu_pkg::cmd_t                 entries [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]    wr_ptr;
  logic [jsu_pkg::QPTR_W-1:0]    rd_ptr;
  logic [jsu_pkg::QCNT_W-1:0]    count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

/* hw/rtl/jsu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Serializer. Expands the command at the queue head into one to four result
// beats, encoding code points as UTF-8, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsu_pkg::cmd_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               res_valid,
  input  wire logic          res_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         kind,
  output logic [2:0]         error_code,
  output logic               last
);

  logic [1:0] idx;
  logic [1:0] nm1;
  logic [7:0] beat_byte;
  logic [1:0] beat_kind;
  logic [2:0] beat_err;
  logic       beat_last;
  logic       load;

  always_comb begin
    nm1       = 2'd0;
    beat_byte = 8'd0;
    beat_kind = jsu_pkg::KIND_DATA;
    beat_err  = 3'd0;
    case (head.op)
      jsu_pkg::OP_BYTE: begin
        beat_byte = head.cp[7:0];
      end
      jsu_pkg::OP_END: begin
        beat_kind = jsu_pkg::KIND_END;
      end
      jsu_pkg::OP_ERR: begin
        beat_kind = jsu_pkg::KIND_ERROR;
        beat_err  = head.err;
      end
      jsu_pkg::OP_CP: begin
        if (head.cp < 21'h80) begin
          nm1       = 2'd0;
          beat_byte = {1'b0, head.cp[6:0]};
        end else if (head.cp < 21'h800) begin
          nm1 = 2'd1;
          case (idx)
            2'd0:    beat_byte = {3'b110, head.cp[10:6]};
            default: beat_byte = {2'b10, head.cp[5:0]};
          endcase
        end else if (head.cp < 21'h10000) begin
          nm1 = 2'd2;
          case (idx)
            2'd0:    beat_byte = {4'b1110, head.cp[15:12]};
            2'd1:    beat_byte = {2'b10, head.cp[11:6]};
            default: beat_byte = {2'b10, head.cp[5:0]};
          endcase
        end else begin
          nm1 = 2'd3;
          case (idx)
            2'd0:    beat_byte = {5'b11110, head.cp[20:18]};
            2'd1:    beat_byte = {2'b10, head.cp[17:12]};
            2'd2:    beat_byte = {2'b10, head.cp[11:6]};
            default: beat_byte = {2'b10, head.cp[5:0]};
          endcase
        end
      end
      default: begin
        beat_kind = jsu_pkg::KIND_DATA;
      end
    endcase
    beat_last = (idx == nm1);
  end

  assign load = head_valid && (!res_valid || !res_stall);
  assign pop  = load && beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= beat_last ? 2'd0 : idx + 2'd1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (load) begin
      out_byte   <= beat_byte;
      kind       <= beat_kind;
      error_code <= beat_err;
      last       <= beat_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_mid_seq_head: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> head_valid)
    else $error("multi-byte sequence in progress with an empty queue");
  a_mid_seq_cp: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> (head.op == jsu_pkg::OP_CP))
    else $error("beat index advanced on a single-beat command");
`endif

endmodule
`default_nettype wire

/* test/json_unescape_checker.sv */
// ----------------------------------------------------------------------------
// json_unescape_checker
// Watches both channels of the JSON string unescape unit. It decodes every
// accepted input beat into the UTF-8, end and error beats it should cause,
// queues them in order, and compares each accepted result beat field by field.
// ----------------------------------------------------------------------------
module json_unescape_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       restart,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [7:0] out_byte,
  input  logic [1:0] kind,
  input  logic [2:0] error_code,
  input  logic       last,
  output int         mismatch_count,
  output int         pending_count
);

  localparam logic [2:0] ERR_NONE = 3'd0;

  typedef enum logic [2:0] {
    ST_BODY,
    ST_ESC,
    ST_HEX,
    ST_LOW_BSL,
    ST_LOW_U,
    ST_ERROR
  } dec_state_t;

  typedef struct packed {
    logic [7:0] ob;
    logic [1:0] k;
    logic [2:0] ec;
    logic       lst;
  } beat_t;

  dec_state_t state = ST_BODY;
  logic [2:0] hex_left = '0;
  logic [31:0] accum = '0;
  beat_t decoded_q[$];
  beat_t byte_beats[$];
  int errors = 0;

  task automatic emit(input logic [7:0] b, input logic [1:0] k, input logic [2:0] ec);
    beat_t t;
    t.ob = b;
    t.k = k;
    t.ec = ec;
    t.lst = 1'b0;
    byte_beats.push_back(t);
  endtask

  task automatic flag_error(input logic [2:0] ec);
    state = ST_ERROR;
    emit(8'h00, jsu_pkg::KIND_ERROR, ec);
  endtask

  task automatic emit_utf8(input logic [31:0] c);
    if (c < 32'h80) begin
      emit(c[7:0], jsu_pkg::KIND_DATA, ERR_NONE);
    end else if (c < 32'h800) begin
      emit({3'b110, c[10:6]}, jsu_pkg::KIND_DATA, ERR_NONE);
      emit({2'b10, c[5:0]}, jsu_pkg::KIND_DATA, ERR_NONE);
    end else if (c < 32'h10000) begin
      emit({4'b1110, c[15:12]}, jsu_pkg::KIND_DATA, ERR_NONE);
      emit({2'b10, c[11:6]}, jsu_pkg::KIND_DATA, ERR_NONE);
      emit({2'b10, c[5:0]}, jsu_pkg::KIND_DATA, ERR_NONE);
    end else if (c < 32'h110000) begin
      emit({5'b11110, c[20:18]}, jsu_pkg::KIND_DATA, ERR_NONE);
      emit({2'b10, c[17:12]}, jsu_pkg::KIND_DATA, ERR_NONE);
      emit({2'b10, c[11:6]}, jsu_pkg::KIND_DATA, ERR_NONE);
      emit({2'b10, c[5:0]}, jsu_pkg::KIND_DATA, ERR_NONE);
    end
  endtask

  function automatic int hex_val(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // A complete four-digit escape: a plain code point, the high half of a
  // pair, or the low half whose value now sits below the high half.
  task automatic finish_code();
    logic [31:0] v;
    logic [31:0] cp;
    v = accum;
    if (v < 32'hd800 || (v >= 32'he000 && v < 32'h10000)) begin
      emit_utf8(v);
      accum = '0;
      state = ST_BODY;
    end else if (v < 32'hdc00) begin
      state = ST_LOW_BSL;
    end else if (v < 32'he000) begin
      flag_error(jsu_pkg::ERR_LONE_LOW);
    end else if ((v & 32'hfc00) == 32'hdc00) begin
      cp = (v >> 6) & 32'h03fffc00;
      cp = cp + (v & 32'hffff);
      cp = cp - 32'h035fdc00;
      emit_utf8(cp);
      accum = '0;
      state = ST_BODY;
    end else begin
      flag_error(jsu_pkg::ERR_BAD_LOW);
    end
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic rs);
    int d;
    beat_t t;
    byte_beats.delete();
    if (rs) begin
      state = ST_BODY;
      hex_left = '0;
      accum = '0;
    end
    case (state)
      ST_BODY: begin
        if (b == 8'h5c) state = ST_ESC;
        else if (b == 8'h22) emit(8'h00, jsu_pkg::KIND_END, ERR_NONE);
        else emit(b, jsu_pkg::KIND_DATA, ERR_NONE);
      end
      ST_ESC: begin
        state = ST_BODY;
        case (b)
          8'h22, 8'h5c, 8'h2f: emit(b, jsu_pkg::KIND_DATA, ERR_NONE);
          "b": emit(8'h08, jsu_pkg::KIND_DATA, ERR_NONE);
          "f": emit(8'h0c, jsu_pkg::KIND_DATA, ERR_NONE);
          "n": emit(8'h0a, jsu_pkg::KIND_DATA, ERR_NONE);
          "r": emit(8'h0d, jsu_pkg::KIND_DATA, ERR_NONE);
          "t": emit(8'h09, jsu_pkg::KIND_DATA, ERR_NONE);
          "u": begin
            state = ST_HEX;
            hex_left = 3'd4;
          end
          default: flag_error(jsu_pkg::ERR_BAD_ESC);
        endcase
      end
      ST_HEX: begin
        d = hex_val(b);
        if (d < 0) begin
          accum = accum << 4;
          if (hex_left != 0) hex_left = hex_left - 3'd1;
          flag_error(jsu_pkg::ERR_BAD_HEX);
        end else begin
          accum = (accum << 4) | 32'(d);
          if (hex_left != 0) hex_left = hex_left - 3'd1;
          if (hex_left == 0) finish_code();
        end
      end
      ST_LOW_BSL: begin
        if (b == 8'h5c) state = ST_LOW_U;
        else flag_error(jsu_pkg::ERR_LOW_EXP);
      end
      ST_LOW_U: begin
        if (b == "u") begin
          state = ST_HEX;
          hex_left = 3'd4;
        end else begin
          flag_error(jsu_pkg::ERR_LOW_EXP);
        end
      end
      default: ;
    endcase
    foreach (byte_beats[i]) begin
      t = byte_beats[i];
      t.lst = (i == byte_beats.size() - 1);
      decoded_q.push_back(t);
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (rst) begin
      state = ST_BODY;
      hex_left = '0;
      accum = '0;
      decoded_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        got = {out_byte, kind, error_code, last};
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result beat: byte %02h kind %0d code %0d last %0d",
                     $time, got.ob, got.k, got.ec, got.lst);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch byte/kind/code/last: expected %02h %0d %0d %0d, got %02h %0d %0d %0d",
                       $time, want.ob, want.k, want.ec, want.lst,
                       got.ob, got.k, got.ec, got.lst);
          end
        end
      end
      if (byte_valid && !byte_stall) unescape_byte(data_byte, restart);
    end
    mismatch_count <= errors;
    pending_count <= decoded_q.size();
  end

endmodule

/* test/json_string_unescape_utf8_unit_tb.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb
// Drives JSON string body bytes into the unescape unit: a short directed run,
// then random well-formed strings, escapes and surrogate pairs mixed with
// malformed escapes, restarts and noise. Both sides idle at random. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit_tb;

  localparam int N_ITEMS = 480;
  localparam int IDLE_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'h00;
  logic       restart = 1'b0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  int mismatch_count;
  int pending_count;
  int idle_cycles = 0;
  bit calm = 1'b0;

  logic [7:0] stim_byte[$];
  bit         stim_rst[$];
  bit         restart_due = 1'b0;
  int         counted = 0;

  json_string_unescape_utf8_unit dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .restart    (restart),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

  json_unescape_checker chk (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .restart        (restart),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_byte       (out_byte),
    .kind           (kind),
    .error_code     (error_code),
    .last           (last),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic bit is_escape_char(input logic [7:0] b);
    return b == 8'h22 || b == 8'h5c || b == 8'h2f || b == "b" || b == "f" ||
           b == "n" || b == "r" || b == "t" || b == "u";
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'(nib) - 8'd10;
    return 8'h41 + 8'(nib) - 8'd10;
  endfunction

  task automatic push_raw(input logic [7:0] b, input bit r);
    stim_byte.push_back(b);
    stim_rst.push_back(r);
  endtask

  // Counted beat; takes a restart that an earlier error asked for, and now
  // and then a stray one that may cut a sequence short.
  task automatic push(input logic [7:0] b);
    push_raw(b, restart_due || ($urandom_range(0, 59) == 0));
    restart_due = 1'b0;
    counted++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_raw(s[i], 1'b0);
  endtask

  task automatic push_uesc(input logic [15:0] v);
    push(8'h5c);
    push("u");
    for (int k = 3; k >= 0; k--) push(hex_char(v[4*k +: 4]));
  endtask

  task automatic push_bad_hex_tail();
    logic [7:0] b;
    int good;
    good = $urandom_range(0, 3);
    push(8'h5c);
    push("u");
    for (int k = 0; k < good; k++) push(hex_char(4'($urandom_range(0, 15))));
    do b = 8'($urandom_range(0, 255)); while (is_hex(b));
    push(b);
  endtask

  task automatic push_error_case();
    logic [7:0] b;
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: begin
        do b = 8'($urandom_range(0, 255)); while (is_escape_char(b));
        push(8'h5c);
        push(b);
      end
      1: push_bad_hex_tail();
      2: push_uesc(16'($urandom_range(16'hdc00, 16'hdfff)));
      3: begin
        push_uesc(16'($urandom_range(16'hd800, 16'hdbff)));
        do b = 8'($urandom_range(0, 255)); while (b == 8'h5c);
        push(b);
      end
      4: begin
        push_uesc(16'($urandom_range(16'hd800, 16'hdbff)));
        push(8'h5c);
        do b = 8'($urandom_range(0, 255)); while (b == "u");
        push(b);
      end
      5: begin
        push_uesc(16'($urandom_range(16'hd800, 16'hdbff)));
        do v = 16'($urandom_range(0, 16'hffff)); while (v >= 16'hdc00 && v <= 16'hdfff);
        push_uesc(v);
      end
      default: begin
        push_uesc(16'($urandom_range(16'hd800, 16'hdbff)));
        push_bad_hex_tail();
      end
    endcase
    // Bytes in the error state are dropped, quotes and backslashes too.
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0: push_raw(8'h22, 1'b0);
        1: push_raw(8'h5c, 1'b0);
        default: push_raw(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
    restart_due = 1'b1;
  endtask

  task automatic build_stimulus();
    int pick;
    logic [7:0] b;
    logic [7:0] esc_chars[8];
    esc_chars = '{8'h22, 8'h5c, 8'h2f, "b", "f", "n", "r", "t"};
    push_raw(8'h00, 1'b1);
    push_raw(8'hff, 1'b0);
    push_raw(8'h22, 1'b0);
    push_str("\\u20AC");
    push_str("\\ud83D\\uDe00");
    push_str("\\q");
    push_raw(8'h22, 1'b0);
    push_raw("x", 1'b1);
    while (counted < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        do b = 8'($urandom_range(0, 255)); while (b == 8'h5c);
        push(b);
      end else if (pick < 34) begin
        push(8'h22);
      end else if (pick < 46) begin
        push(8'h5c);
        push(esc_chars[$urandom_range(0, 7)]);
      end else if (pick < 66) begin
        case ($urandom_range(0, 3))
          0: push_uesc(16'($urandom_range(0, 16'h7f)));
          1: push_uesc(16'($urandom_range(16'h80, 16'h7ff)));
          2: push_uesc(16'($urandom_range(16'h800, 16'hd7ff)));
          default: push_uesc(16'($urandom_range(16'he000, 16'hffff)));
        endcase
      end else if (pick < 78) begin
        push_uesc(16'($urandom_range(16'hd800, 16'hdbff)));
        push_uesc(16'($urandom_range(16'hdc00, 16'hdfff)));
      end else if (pick < 95) begin
        push_error_case();
      end else begin
        restart_due = 1'b1;
        push(8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(negedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < stim_byte.size(); i++) begin
      calm = (i >= 150 && i < 300);
      while (!calm && $urandom_range(0, 99) < 12) begin
        byte_valid <= 1'b0;
        @(negedge clk);
      end
      byte_valid <= 1'b1;
      data_byte <= stim_byte[i];
      restart <= stim_rst[i];
      @(posedge clk);
      while (byte_stall) @(posedge clk);
      @(negedge clk);
    end
    byte_valid <= 1'b0;
    calm = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
